// ----- rtl/core/hashed_key_value_store_top_macros.svh -----
// Assertion macros shared by the key-value store RTL.
`ifndef HASHED_KEY_VALUE_STORE_TOP_MACROS_SVH
`define HASHED_KEY_VALUE_STORE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define HKV_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define HKV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HKV_ASSERT(label, clk, rstn, ante, cons, msg)
`define HKV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/core/hkv_pkg.sv -----
// Types and constants shared by the key-value store modules.
`timescale 1ns / 1ps
package hkv_pkg;

    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int COUNT_MAX   = 127;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Binary to decimal conversion of the key.
    localparam int BCD_DIGITS     = 20;
    localparam int BITS_PER_STEP  = 4;
    localparam int CONV_STEPS     = KEY_W / BITS_PER_STEP;
    localparam int DIGITS_PER_SUM = 4;
    localparam int SUM_STEPS      = BCD_DIGITS / DIGITS_PER_SUM;
    localparam int STEP_W         = $clog2(CONV_STEPS);

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } hkv_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [VAL_W-1:0]       read_value;
        logic [COUNT_OUT_W-1:0] entry_count;
    } hkv_res_t;

    typedef struct packed {
        logic ready;
        logic done;
    } hkv_tbl_ctl_t;

endpackage

// ----- rtl/core/hkv_hash.sv -----
// Bucket hash: decimal digit sum of the key, reduced modulo the bucket count.
`timescale 1ns / 1ps
module hkv_hash #(
    parameter int  BUCKETS = 16,
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [hkv_pkg::KEY_W-1:0] key,
    output logic                    done,
    output logic [BKT_W-1:0]        bucket
);
    import hkv_pkg::*;

    localparam int BCD_W = BCD_DIGITS * 4;
    localparam int SUM_W = $clog2((DIGITS_PER_SUM + 1) * BUCKETS + 1);

    // Each decimal digit (and the unused nibble codes) reduced modulo BUCKETS.
    localparam logic [BKT_W-1:0] DIGIT_MOD [16] = '{
        BKT_W'(0 % BUCKETS),  BKT_W'(1 % BUCKETS),  BKT_W'(2 % BUCKETS),  BKT_W'(3 % BUCKETS),
        BKT_W'(4 % BUCKETS),  BKT_W'(5 % BUCKETS),  BKT_W'(6 % BUCKETS),  BKT_W'(7 % BUCKETS),
        BKT_W'(8 % BUCKETS),  BKT_W'(9 % BUCKETS),  BKT_W'(10 % BUCKETS), BKT_W'(11 % BUCKETS),
        BKT_W'(12 % BUCKETS), BKT_W'(13 % BUCKETS), BKT_W'(14 % BUCKETS), BKT_W'(15 % BUCKETS)
    };

    typedef enum logic [1:0] {H_IDLE, H_CONV, H_SUM} hash_state_t;

    hash_state_t        state_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [KEY_W-1:0]   bits_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [BKT_W-1:0]   acc_reg;
    logic [BKT_W-1:0]   acc_next;
    logic               done_reg;
    logic [SUM_W-1:0]   sum;

    // Shift-and-add-3 conversion, several key bits per call.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                input logic [BITS_PER_STEP-1:0] bits);
        logic [BCD_W-1:0] v;
        v = bcd;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (v[d*4 +: 4] >= 4'd5) begin
                    v[d*4 +: 4] = v[d*4 +: 4] + 4'd3;
                end
            end
            v = {v[BCD_W-2:0], bits[BITS_PER_STEP-1-s]};
        end
        return v;
    endfunction

    // The accumulator stays below BUCKETS, so a few conditional
    // subtractions bring the partial sum back into range.
    always_comb begin
        sum = SUM_W'(acc_reg);
        for (int j = 0; j < DIGITS_PER_SUM; j++) begin
            sum = sum + SUM_W'(DIGIT_MOD[bcd_reg[j*4 +: 4]]);
        end
        for (int r = 0; r < DIGITS_PER_SUM; r++) begin
            if (sum >= SUM_W'(BUCKETS)) begin
                sum = sum - SUM_W'(BUCKETS);
            end
        end
        acc_next = sum[BKT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE: begin
                    if (start) begin
                        bcd_reg   <= '0;
                        bits_reg  <= key;
                        step_reg  <= '0;
                        state_reg <= H_CONV;
                    end
                end
                H_CONV: begin
                    bcd_reg  <= dabble(bcd_reg, bits_reg[KEY_W-1 -: BITS_PER_STEP]);
                    bits_reg <= bits_reg << BITS_PER_STEP;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(CONV_STEPS - 1)) begin
                        step_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= H_SUM;
                    end
                end
                H_SUM: begin
                    acc_reg  <= acc_next;
                    bcd_reg  <= bcd_reg >> (DIGITS_PER_SUM * 4);
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SUM_STEPS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end
                end
                default: begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign bucket = acc_reg;

endmodule

// ----- rtl/core/hkv_table.sv -----
// Entry memory with bucket way scan, update sequencer and key counter.
`timescale 1ns / 1ps
`include "hashed_key_value_store_top_macros.svh"
module hkv_table #(
    parameter int  BUCKETS = 16,
    parameter int  WAYS    = 4,
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  hkv_pkg::hkv_req_t     req,
    input  logic [BKT_W-1:0]      bucket,
    output hkv_pkg::hkv_tbl_ctl_t ctl,
    output hkv_pkg::hkv_res_t     res
);
    import hkv_pkg::*;

    localparam int SLOTS   = BUCKETS * WAYS;
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int COUNT_W = $clog2(SLOTS + 1);
    localparam int WIDE_W  = COUNT_W + COUNT_OUT_W;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef enum logic [2:0] {T_CLEAR, T_IDLE, T_SCAN, T_LAST, T_DECIDE} tbl_state_t;

    entry_t mem [SLOTS];

    tbl_state_t           state_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [WAY_W-1:0]     way_reg;
    logic                 cmp_valid_reg;
    logic [ADDR_W-1:0]    cmp_addr_reg;
    entry_t               rdata_reg;
    hkv_req_t             req_reg;
    logic                 hit_reg;
    logic [ADDR_W-1:0]    hit_addr_reg;
    logic [VAL_W-1:0]     hit_value_reg;
    logic                 free_reg;
    logic [ADDR_W-1:0]    free_addr_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 done_reg;
    hkv_res_t             res_reg;

    logic                 cmp_match;
    logic                 cmp_free;
    logic [STATUS_W-1:0]  dec_status;
    logic [VAL_W-1:0]     dec_rd;
    logic                 dec_we;
    logic [ADDR_W-1:0]    dec_waddr;
    entry_t               dec_wdata;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    entry_t               mem_wdata;
    logic [WIDE_W-1:0]    count_wide;
    logic [COUNT_OUT_W-1:0] count_sat;

    // The word read in one scan cycle is compared in the next.
    assign cmp_match = cmp_valid_reg && rdata_reg.valid && (rdata_reg.key == req_reg.key);
    assign cmp_free  = cmp_valid_reg && !rdata_reg.valid;

    always_comb begin
        dec_status = ST_OK;
        dec_rd     = '0;
        count_next = count_reg;
        dec_we     = 1'b0;
        dec_waddr  = hit_addr_reg;
        dec_wdata  = '{valid: 1'b1, key: req_reg.key, value: req_reg.value};
        case (req_reg.cmd)
            CMD_GET: begin
                if (hit_reg) begin
                    dec_rd = hit_value_reg;
                end else begin
                    dec_status = ST_NOT_FOUND;
                end
            end
            CMD_SET: begin
                if (hit_reg) begin
                    dec_we = 1'b1;
                end else if (free_reg) begin
                    dec_we     = 1'b1;
                    dec_waddr  = free_addr_reg;
                    count_next = count_reg + COUNT_W'(1);
                end else begin
                    dec_status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (hit_reg) begin
                    dec_we          = 1'b1;
                    dec_wdata.valid = 1'b0;
                    dec_rd          = hit_value_reg;
                    if (count_reg != '0) begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                end else begin
                    dec_status = ST_NOT_FOUND;
                end
            end
            default: begin
                dec_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        count_wide = WIDE_W'(count_next);
        if (count_wide > WIDE_W'(COUNT_MAX)) begin
            count_sat = COUNT_OUT_W'(COUNT_MAX);
        end else begin
            count_sat = count_wide[COUNT_OUT_W-1:0];
        end
    end

    // The clearing pass after reset owns the write port until it ends.
    always_comb begin
        if (state_reg == T_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = (state_reg == T_DECIDE) && dec_we;
            mem_waddr = dec_waddr;
            mem_wdata = dec_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_CLEAR;
            addr_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end else begin
            done_reg      <= 1'b0;
            cmp_valid_reg <= (state_reg == T_SCAN);
            cmp_addr_reg  <= addr_reg;
            if (cmp_match && !hit_reg) begin
                hit_reg       <= 1'b1;
                hit_addr_reg  <= cmp_addr_reg;
                hit_value_reg <= rdata_reg.value;
            end
            if (cmp_free && !free_reg) begin
                free_reg      <= 1'b1;
                free_addr_reg <= cmp_addr_reg;
            end
            case (state_reg)
                T_CLEAR: begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (addr_reg == ADDR_W'(SLOTS - 1)) begin
                        state_reg <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (start) begin
                        req_reg   <= req;
                        addr_reg  <= ADDR_W'(bucket) * ADDR_W'(WAYS);
                        way_reg   <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        state_reg <= T_SCAN;
                    end
                end
                T_SCAN: begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    way_reg  <= way_reg + WAY_W'(1);
                    if (way_reg == WAY_W'(WAYS - 1)) begin
                        state_reg <= T_LAST;
                    end
                end
                T_LAST: begin
                    state_reg <= T_DECIDE;
                end
                T_DECIDE: begin
                    count_reg <= count_next;
                    res_reg   <= '{status: dec_status, read_value: dec_rd,
                                   entry_count: count_sat};
                    done_reg  <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign ctl = '{ready: (state_reg == T_IDLE), done: done_reg};
    assign res = res_reg;

    `HKV_ASSERT(a_start_when_idle, aclk, aresetn, start, state_reg == T_IDLE, "table started while busy")
    `HKV_ASSERT(a_count_bound, aclk, aresetn, 1'b1, count_reg <= COUNT_W'(SLOTS), "key count beyond slots")
    `HKV_ASSERT_NEXT(a_decide_done, aclk, aresetn, state_reg == T_DECIDE, done_reg && state_reg == T_IDLE, "decision did not complete")
    `HKV_ASSERT(a_no_write_in_scan, aclk, aresetn, state_reg == T_SCAN || state_reg == T_LAST, !mem_we, "memory written during scan")

endmodule

// ----- rtl/core/hashed_key_value_store_top.sv -----
// Top level of the hashed key-value store.
// Input channel (s_valid/s_ready): one request word carries s_command (get, set,
// remove), s_key and s_new_value. Output channel (m_valid/m_ready): one result
// word per request with m_status, m_read_value and m_entry_count.
// Flow: once a request is accepted, the hash unit converts its key from binary
// to decimal and sums the digits; the table then reads one word per way of the
// bucket, compares each with the key and, in a decision step, writes the entry
// when a set finds its key or a free way or a remove finds its key. The result
// then moves to the output register. One request is in flight at a time, so a
// new word is taken only once the previous result is in the output register.
// Reset: aresetn is synchronous and active low. After its release the entry
// memory is swept once, one entry a cycle over all BUCKETS * WAYS entries (64 by
// default), and s_ready stays low until the sweep ends.
// Stall: a finished result waits in the output register while m_ready is low;
// the next request may already be accepted and worked on, and its result
// waits in the table until the output register is free.
`timescale 1ns / 1ps
`include "hashed_key_value_store_top_macros.svh"
module hashed_key_value_store_top #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hkv_pkg::CMD_W-1:0]      s_command,
    input  logic [hkv_pkg::KEY_W-1:0]      s_key,
    input  logic [hkv_pkg::VAL_W-1:0]      s_new_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hkv_pkg::STATUS_W-1:0]   m_status,
    output logic [hkv_pkg::VAL_W-1:0]      m_read_value,
    output logic [hkv_pkg::COUNT_OUT_W-1:0] m_entry_count
);
    import hkv_pkg::*;

    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_HASH, S_TABLE, S_PEND} top_state_t;

    top_state_t             state_reg;
    hkv_req_t               req_reg;
    logic                   m_valid_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [VAL_W-1:0]       m_read_value_reg;
    logic [COUNT_OUT_W-1:0] m_entry_count_reg;

    logic                   accept;
    logic                   hash_done;
    logic [BKT_W-1:0]       hash_bucket;
    hkv_tbl_ctl_t           tbl_ctl;
    hkv_res_t               tbl_res;

    assign s_ready = (state_reg == S_IDLE) && tbl_ctl.ready;
    assign accept  = s_valid && s_ready;

    hkv_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (s_key),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    hkv_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_done),
        .req     (req_reg),
        .bucket  (hash_bucket),
        .ctl     (tbl_ctl),
        .res     (tbl_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // In the pending state the load below alone decides the valid flag.
            if (m_valid_reg && m_ready && (state_reg != S_PEND)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg   <= '{cmd: s_command, key: s_key, value: s_new_value};
                        state_reg <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        state_reg <= S_TABLE;
                    end
                end
                S_TABLE: begin
                    if (tbl_ctl.done) begin
                        state_reg <= S_PEND;
                    end
                end
                S_PEND: begin
                    // The table holds its result until the next request is decided.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_status_reg      <= tbl_res.status;
                        m_read_value_reg  <= tbl_res.read_value;
                        m_entry_count_reg <= tbl_res.entry_count;
                        state_reg         <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_entry_count = m_entry_count_reg;

    `HKV_ASSERT(a_hash_done_state, aclk, aresetn, hash_done, state_reg == S_HASH, "hash finished outside hash state")
    `HKV_ASSERT(a_table_done_state, aclk, aresetn, tbl_ctl.done, state_reg == S_TABLE, "table finished outside table state")
    `HKV_ASSERT_NEXT(a_pend_loads, aclk, aresetn, state_reg == S_PEND && (!m_valid_reg || m_ready), m_valid_reg && state_reg == S_IDLE, "pending result not loaded")

endmodule
